>>> rtl/core/ihc_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the IPv4 header checker.
package ihc_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned PosW   = 5;

  localparam logic [CountW-1:0] HDR_BYTES     = 16'd20;
  localparam logic [CountW-1:0] COUNT_MAX     = 16'hffff;
  localparam logic [15:0]       MAX_LEN_RESET = 16'd1500;
  localparam logic [3:0]        IP_VERSION    = 4'd4;
  localparam logic [3:0]        IP_IHL        = 4'd5;
  localparam logic [15:0]       FRAG_MASK     = 16'hbfff;
  localparam logic [15:0]       SUM_GOOD      = 16'hffff;

  // header byte positions
  localparam logic [PosW-1:0] POS_VER_IHL   = 5'd0;
  localparam logic [PosW-1:0] POS_LEN_HI    = 5'd2;
  localparam logic [PosW-1:0] POS_LEN_LO    = 5'd3;
  localparam logic [PosW-1:0] POS_FRAG_HI   = 5'd6;
  localparam logic [PosW-1:0] POS_FRAG_LO   = 5'd7;
  localparam logic [PosW-1:0] POS_TTL       = 5'd8;
  localparam logic [PosW-1:0] POS_PROTO     = 5'd9;
  localparam logic [PosW-1:0] POS_SRC_FIRST = 5'd12;
  localparam logic [PosW-1:0] POS_SRC_LAST  = 5'd15;
  localparam logic [PosW-1:0] POS_DST_FIRST = 5'd16;
  localparam logic [PosW-1:0] POS_DST_LAST  = 5'd19;

  typedef struct packed {
    logic        ok;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [7:0]  protocol;
    logic [15:0] payload_length;
  } verdict_t;

endpackage

>>> rtl/core/ihc_in_if.sv
`timescale 1ns / 1ps
// Byte input channel: valid/ready with one buffer byte and an end flag.
interface ihc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink (input valid, input data_byte, input last, output ready);
endinterface

>>> rtl/core/ihc_out_if.sv
`timescale 1ns / 1ps
// Verdict output channel: valid/ready with the check result and header fields.
interface ihc_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] source_addr;
  logic [31:0] dest_addr;
  logic [7:0]  protocol;
  logic [15:0] payload_length;

  modport source (output valid, output ok, output source_addr, output dest_addr,
                  output protocol, output payload_length, input ready);
  modport sink (input valid, input ok, input source_addr, input dest_addr,
                input protocol, input payload_length, output ready);
endinterface

>>> rtl/core/ipv4_header_check.sv
`timescale 1ns / 1ps
// IPv4 header checker: byte-wise capture, checksum and one verdict per buffer.
//
//  channel   | direction | handshake        | content
//  ----------+-----------+------------------+--------------------------------------
//  in_chan   | in        | valid/ready      | data_byte, last
//  out_chan  | out       | valid/ready      | ok, addresses, protocol, payload len
//  cfg_*     | in        | write enable     | max_total_length (16 bits)
//
// One byte per cycle; a verdict is presented in the cycle after the byte flagged last is accepted.
// The output register frees in the cycle it is taken, so bytes keep flowing
// unless a verdict sits untaken, which stalls the input.
// Synchronous active-low reset clears packet state and sets the maximum to 1500.
module ipv4_header_check (
  input  logic         clk,
  input  logic         rst_n,
  ihc_in_if.sink       in_chan,
  ihc_out_if.source    out_chan,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);

  logic [15:0] max_len_r;
  logic [15:0] byte_count_r, byte_count_nxt;
  logic [15:0] sum_acc_r, sum_acc_nxt;
  logic [7:0]  high_byte_r, high_byte_nxt;
  logic [7:0]  version_ihl_r, version_ihl_nxt;
  logic [15:0] total_len_r, total_len_nxt;
  logic [15:0] flags_frag_r, flags_frag_nxt;
  logic [7:0]  ttl_r, ttl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;

  logic                 out_valid_r;
  ihc_pkg::verdict_t    verdict_r, verdict_nxt;

  logic                          accept;
  logic                          in_hdr;
  logic [ihc_pkg::PosW-1:0]      pos;
  logic [7:0]                    b;
  logic [16:0]                   word_sum;
  logic                          ok_nxt;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign b             = in_chan.data_byte;
  assign pos           = byte_count_r[ihc_pkg::PosW-1:0];
  assign in_hdr        = byte_count_r < ihc_pkg::HDR_BYTES;

  always_comb begin
    high_byte_nxt   = high_byte_r;
    sum_acc_nxt     = sum_acc_r;
    version_ihl_nxt = version_ihl_r;
    total_len_nxt   = total_len_r;
    flags_frag_nxt  = flags_frag_r;
    ttl_nxt         = ttl_r;
    proto_nxt       = proto_r;
    src_nxt         = src_r;
    dst_nxt         = dst_r;
    word_sum        = {1'b0, sum_acc_r} + {1'b0, high_byte_r, b};

    if (in_hdr) begin
      if (!pos[0]) begin
        high_byte_nxt = b;
      end else begin
        // end-around carry
        sum_acc_nxt = word_sum[15:0] + {15'd0, word_sum[16]};
      end
      case (pos) inside
        ihc_pkg::POS_VER_IHL: version_ihl_nxt = b;
        ihc_pkg::POS_LEN_HI:  total_len_nxt   = {b, total_len_r[7:0]};
        ihc_pkg::POS_LEN_LO:  total_len_nxt   = {total_len_r[15:8], b};
        ihc_pkg::POS_FRAG_HI: flags_frag_nxt  = {b, flags_frag_r[7:0]};
        ihc_pkg::POS_FRAG_LO: flags_frag_nxt  = {flags_frag_r[15:8], b};
        ihc_pkg::POS_TTL:     ttl_nxt         = b;
        ihc_pkg::POS_PROTO:   proto_nxt       = b;
        [ihc_pkg::POS_SRC_FIRST:ihc_pkg::POS_SRC_LAST]: src_nxt = {src_r[23:0], b};
        [ihc_pkg::POS_DST_FIRST:ihc_pkg::POS_DST_LAST]: dst_nxt = {dst_r[23:0], b};
        default: ;
      endcase
    end

    byte_count_nxt = (byte_count_r == ihc_pkg::COUNT_MAX) ? byte_count_r
                                                          : byte_count_r + 16'd1;

    ok_nxt = (byte_count_nxt >= ihc_pkg::HDR_BYTES)
          && (version_ihl_nxt[7:4] == ihc_pkg::IP_VERSION)
          && (version_ihl_nxt[3:0] == ihc_pkg::IP_IHL)
          && (total_len_nxt >= ihc_pkg::HDR_BYTES)
          && (total_len_nxt <= byte_count_nxt)
          && (total_len_nxt <= max_len_r)
          && (ttl_nxt != 8'd0)
          && ((flags_frag_nxt & ihc_pkg::FRAG_MASK) == 16'd0)
          && (sum_acc_nxt == ihc_pkg::SUM_GOOD);

    verdict_nxt = '0;
    if (ok_nxt) begin
      verdict_nxt.ok             = 1'b1;
      verdict_nxt.source_addr    = src_nxt;
      verdict_nxt.dest_addr      = dst_nxt;
      verdict_nxt.protocol       = proto_nxt;
      verdict_nxt.payload_length = total_len_nxt - ihc_pkg::HDR_BYTES;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= ihc_pkg::MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_chan.last)) begin
      byte_count_r  <= '0;
      sum_acc_r     <= '0;
      high_byte_r   <= '0;
      version_ihl_r <= '0;
      total_len_r   <= '0;
      flags_frag_r  <= '0;
      ttl_r         <= '0;
      proto_r       <= '0;
      src_r         <= '0;
      dst_r         <= '0;
    end else if (accept) begin
      byte_count_r  <= byte_count_nxt;
      sum_acc_r     <= sum_acc_nxt;
      high_byte_r   <= high_byte_nxt;
      version_ihl_r <= version_ihl_nxt;
      total_len_r   <= total_len_nxt;
      flags_frag_r  <= flags_frag_nxt;
      ttl_r         <= ttl_nxt;
      proto_r       <= proto_nxt;
      src_r         <= src_nxt;
      dst_r         <= dst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_chan.last) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_chan.last) begin
      verdict_r <= verdict_nxt;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.ok             = verdict_r.ok;
  assign out_chan.source_addr    = verdict_r.source_addr;
  assign out_chan.dest_addr      = verdict_r.dest_addr;
  assign out_chan.protocol       = verdict_r.protocol;
  assign out_chan.payload_length = verdict_r.payload_length;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for ipv4_header_check: directed header table, then random buffers.
module tb_top;
  import ihc_pkg::*;

  localparam int HALF_PERIOD = 2;
  localparam int RESET_CYCLES = 9;
  localparam int unsigned WATCHDOG_CYCLES = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_BYTES = 100;
  localparam int unsigned REPORT_CAP = 40;

  typedef enum logic [1:0] {CSUM_OK, CSUM_BAD, CSUM_RAW} csum_mode_t;

  typedef logic [19:0][7:0] hdr_bytes_t;

  typedef struct {
    logic [7:0]  ver_ihl;
    logic [15:0] tlen;
    logic [15:0] frag;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    csum_mode_t  csum;
  } hdr_fields_t;

  typedef struct {
    logic [15:0] max_len;
    hdr_fields_t f;
    int unsigned n;
    logic        drop;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  ihc_in_if  in_chan ();
  ihc_out_if out_chan ();

  ipv4_header_check dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [15:0] len_limit;
  logic [15:0] hdr_cnt;
  logic [15:0] sum_cap;
  logic [7:0]  word_hi;
  logic [7:0]  ver_ihl_cap;
  logic [15:0] tlen_cap;
  logic [15:0] frag_cap;
  logic [7:0]  ttl_cap;
  logic [7:0]  proto_cap;
  logic [31:0] src_cap;
  logic [31:0] dst_cap;

  verdict_t    verdicts_due [$];
  verdict_t    want;
  bit          calm;
  int unsigned mismatches;
  int unsigned verdicts_seen;
  int unsigned bytes_sent;
  int unsigned buffers_sent;
  int unsigned quiet;
  int unsigned hold_left;
  int unsigned stall;
  plan_row_t   plan [22];

  always #(HALF_PERIOD) clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic start_buffer();
    hdr_cnt = '0;
    sum_cap = '0;
    word_hi = '0;
    ver_ihl_cap = '0;
    tlen_cap = '0;
    frag_cap = '0;
    ttl_cap = '0;
    proto_cap = '0;
    src_cap = '0;
    dst_cap = '0;
  endtask

  task automatic fold_header_byte(input logic [7:0] b, input logic fin, output logic done,
                                  output verdict_t v);
    logic [16:0]     s;
    logic [PosW-1:0] pos;
    logic            pass;
    done = 1'b0;
    v = '0;
    if (hdr_cnt < HDR_BYTES) begin
      pos = hdr_cnt[PosW-1:0];
      if (!pos[0]) begin
        word_hi = b;
      end else begin
        s = {1'b0, sum_cap} + {1'b0, word_hi, b};
        sum_cap = s[15:0] + {15'd0, s[16]};
      end
      case (pos)
        POS_VER_IHL: ver_ihl_cap = b;
        POS_LEN_HI:  tlen_cap[15:8] = b;
        POS_LEN_LO:  tlen_cap[7:0] = b;
        POS_FRAG_HI: frag_cap[15:8] = b;
        POS_FRAG_LO: frag_cap[7:0] = b;
        POS_TTL:     ttl_cap = b;
        POS_PROTO:   proto_cap = b;
        default: ;
      endcase
      if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) begin
        src_cap = {src_cap[23:0], b};
      end else if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) begin
        dst_cap = {dst_cap[23:0], b};
      end
    end
    if (hdr_cnt != COUNT_MAX) hdr_cnt = hdr_cnt + 16'd1;
    if (fin) begin
      pass = hdr_cnt >= HDR_BYTES
          && ver_ihl_cap[7:4] == IP_VERSION
          && ver_ihl_cap[3:0] == IP_IHL
          && tlen_cap >= HDR_BYTES
          && tlen_cap <= hdr_cnt
          && tlen_cap <= len_limit
          && ttl_cap != 8'd0
          && (frag_cap & FRAG_MASK) == 16'd0
          && sum_cap == SUM_GOOD;
      if (pass) v = '{1'b1, src_cap, dst_cap, proto_cap, tlen_cap - HDR_BYTES};
      done = 1'b1;
      start_buffer();
    end
  endtask

  function automatic hdr_bytes_t build_header(input hdr_fields_t f);
    hdr_bytes_t  h;
    logic [16:0] acc;
    logic [15:0] csum;
    h = '0;
    h[0] = f.ver_ihl;
    if (f.csum != CSUM_RAW) begin
      h[1] = 8'($urandom);
      h[4] = 8'($urandom);
      h[5] = 8'($urandom);
    end
    {h[2], h[3]} = f.tlen;
    {h[6], h[7]} = f.frag;
    h[8] = f.ttl;
    h[9] = f.proto;
    {h[12], h[13], h[14], h[15]} = f.src;
    {h[16], h[17], h[18], h[19]} = f.dst;
    acc = '0;
    for (int i = 0; i < 20; i += 2) begin
      acc = {1'b0, acc[15:0]} + {1'b0, h[i], h[i+1]};
      acc = {1'b0, acc[15:0] + {15'd0, acc[16]}};
    end
    csum = ~acc[15:0];
    if (f.csum == CSUM_BAD) csum[0] = ~csum[0];
    if (f.csum != CSUM_RAW) {h[10], h[11]} = csum;
    return h;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin, output logic done,
                           output verdict_t v);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data_byte <= b;
    in_chan.last <= fin;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    fold_header_byte(b, fin, done, v);
    bytes_sent++;
  endtask

  task automatic send_buffer(input hdr_fields_t f, input int unsigned n, input logic drop);
    hdr_bytes_t h;
    logic [7:0] b;
    logic       done;
    verdict_t   v;
    h = build_header(f);
    for (int unsigned i = 0; i < n; i++) begin
      b = (i < 20) ? h[i] : 8'($urandom);
      send_byte(b, i == n - 1, done, v);
      if (done) verdicts_due.push_back(drop ? verdict_t'('0) : v);
    end
    buffers_sent++;
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_max_len(input logic [15:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    len_limit = value;
  endtask

  task automatic draw_buffer(output hdr_fields_t f, output int unsigned n);
    int unsigned kind;
    int unsigned r;
    int unsigned top;
    kind = $urandom_range(0, 99);
    r = $urandom_range(0, 99);
    n = (r < 85) ? $urandom_range(20, 40) : (r < 97) ? $urandom_range(41, 200)
                                                      : $urandom_range(201, 600);
    f.ver_ihl = {IP_VERSION, IP_IHL};
    f.frag = '0;
    f.frag[14] = 1'($urandom);
    f.ttl = 8'($urandom_range(1, 255));
    f.proto = 8'($urandom);
    f.src = $urandom;
    f.dst = $urandom;
    f.csum = CSUM_OK;
    top = (n < len_limit) ? n : len_limit;
    f.tlen = ($urandom_range(0, 4) == 0) ? 16'(top) : 16'($urandom_range(20, top));
    if (kind >= 95) begin
      n = $urandom_range(1, 60);
      f.ver_ihl = 8'($urandom);
      f.tlen = 16'($urandom);
      f.frag = 16'($urandom);
      f.ttl = 8'($urandom);
      f.csum = $urandom_range(0, 1) ? CSUM_OK : CSUM_BAD;
    end else if (kind >= 85) begin
      n = $urandom_range(1, 19);
    end else if (kind >= 55) begin
      case ($urandom_range(0, 8))
        0: f.ver_ihl[7:4] = IP_VERSION ^ 4'($urandom_range(1, 15));
        1: f.ver_ihl[3:0] = IP_IHL ^ 4'($urandom_range(1, 15));
        2: f.ttl = '0;
        3: f.frag[$urandom_range(0, 1) ? 15 : 13] = 1'b1;
        4: f.frag[12:0] = 13'($urandom_range(1, 8191));
        5: f.tlen = 16'($urandom_range(0, 19));
        6: f.tlen = 16'(n + $urandom_range(1, 40));
        7: begin
          f.tlen = (len_limit != 16'hffff) ? len_limit + 16'd1 : 16'(n + 1);
          if (f.tlen <= 600 && n < f.tlen) n = f.tlen;
        end
        default: f.csum = CSUM_BAD;
      endcase
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] exp);
    if (mismatches < REPORT_CAP)
      $display("[%0t] verdict %0d: %s got %0h, expected %0h", $time, verdicts_seen, what,
               got, exp);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_chan.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      stall = pick_gap();
      out_chan.ready <= (stall == 0);
      hold_left <= (stall == 0) ? 0 : stall - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (verdicts_due.size() == 0) begin
        flag_mismatch("unexpected verdict, ok", 32'(out_chan.ok), 32'd0);
      end else begin
        want = verdicts_due.pop_front();
        if (out_chan.ok !== want.ok)
          flag_mismatch("ok", 32'(out_chan.ok), 32'(want.ok));
        if (out_chan.source_addr !== want.source_addr)
          flag_mismatch("source_addr", out_chan.source_addr, want.source_addr);
        if (out_chan.dest_addr !== want.dest_addr)
          flag_mismatch("dest_addr", out_chan.dest_addr, want.dest_addr);
        if (out_chan.protocol !== want.protocol)
          flag_mismatch("protocol", 32'(out_chan.protocol), 32'(want.protocol));
        if (out_chan.payload_length !== want.payload_length)
          flag_mismatch("payload_length", 32'(out_chan.payload_length),
                        32'(want.payload_length));
      end
      verdicts_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_CYCLES) begin
      $display("watchdog: no handshake for %0d cycles, %0d verdicts outstanding", quiet,
               verdicts_due.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    hdr_fields_t f;
    int unsigned n;
    int unsigned mark;
    logic [15:0] phase_limit [6];

    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.data_byte = '0;
    in_chan.last = 1'b0;
    out_chan.ready = 1'b0;
    calm = 1'b0;
    len_limit = MAX_LEN_RESET;
    start_buffer();

    // max, {ver_ihl, tlen, frag, ttl, proto, src, dst, csum}, bytes, typed reject
    plan = '{
      '{100, '{'h45, 100, 'h0, 64, 'h06, 'hc0a80001, 'h0a000001, CSUM_OK}, 100, 0},
      '{100, '{'h45, 101, 'h0, 64, 'h06, 'hc0a80001, 'h0a000001, CSUM_OK}, 101, 1},
      '{1500, '{'h45, 20, 'h0, 1, 'h00, 'h0, 'h0, CSUM_OK}, 20, 0},
      '{1500, '{'h45, 20, 'h4000, 255, 'hff, 'hffffffff, 'hffffffff, CSUM_OK}, 20, 0},
      '{1500, '{'h45, 20, 'h0, 64, 'h11, 'h01020304, 'h05060708, CSUM_OK}, 1, 1},
      '{1500, '{'h45, 20, 'h0, 64, 'h11, 'h01020304, 'h05060708, CSUM_OK}, 19, 1},
      '{1500, '{'h00, 0, 'h0, 0, 'h00, 'h0, 'h0, CSUM_RAW}, 20, 1},
      '{1500, '{'h65, 20, 'h0, 64, 'h06, 'h0a0a0a0a, 'h0b0b0b0b, CSUM_OK}, 20, 1},
      '{1500, '{'h46, 24, 'h0, 64, 'h06, 'h0a0a0a0a, 'h0b0b0b0b, CSUM_OK}, 24, 1},
      '{1500, '{'h45, 19, 'h0, 64, 'h06, 'h0a0a0a0a, 'h0b0b0b0b, CSUM_OK}, 20, 1},
      '{1500, '{'h45, 40, 'h0, 64, 'h06, 'h0a0a0a0a, 'h0b0b0b0b, CSUM_OK}, 30, 1},
      '{1500, '{'h45, 20, 'h0, 0, 'h06, 'h0a0a0a0a, 'h0b0b0b0b, CSUM_OK}, 20, 1},
      '{1500, '{'h45, 20, 'h2000, 64, 'h06, 'h0a0a0a0a, 'h0b0b0b0b, CSUM_OK}, 20, 1},
      '{1500, '{'h45, 20, 'h0001, 64, 'h06, 'h0a0a0a0a, 'h0b0b0b0b, CSUM_OK}, 20, 1},
      '{1500, '{'h45, 20, 'h1fff, 64, 'h06, 'h0a0a0a0a, 'h0b0b0b0b, CSUM_OK}, 20, 1},
      '{1500, '{'h45, 20, 'h0, 64, 'h06, 'h0a0a0a0a, 'h0b0b0b0b, CSUM_BAD}, 20, 1},
      '{1500, '{'h45, 20, 'h0, 64, 'h06, 'h80000001, 'h7ffffffe, CSUM_OK}, 100, 0},
      '{1500, '{'h45, 60, 'h4000, 2, 'h01, 'hac100001, 'hac1000fe, CSUM_OK}, 60, 0},
      '{65535, '{'h45, 200, 'h0, 128, 'h11, 'h0a000002, 'h0a000003, CSUM_OK}, 200, 0},
      '{20, '{'h45, 21, 'h0, 64, 'h06, 'h0a0a0a0a, 'h0b0b0b0b, CSUM_OK}, 21, 1},
      '{20, '{'h45, 20, 'h0, 64, 'h06, 'h0a0a0a0a, 'h0b0b0b0b, CSUM_OK}, 20, 0},
      '{19, '{'h45, 20, 'h0, 64, 'h06, 'h0a0a0a0a, 'h0b0b0b0b, CSUM_OK}, 20, 1}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].max_len != len_limit) set_max_len(plan[i].max_len);
      calm = plan[i].n > 1000;
      send_buffer(plan[i].f, plan[i].n, plan[i].drop);
    end

    phase_limit[0] = 16'd1500;
    phase_limit[1] = 16'hffff;
    phase_limit[2] = 16'd20;
    phase_limit[3] = 16'($urandom_range(20, 65535));
    phase_limit[4] = 16'd576;
    phase_limit[5] = 16'd1500;
    foreach (phase_limit[p]) begin
      set_max_len(phase_limit[p]);
      calm = (p == 3);
      mark = bytes_sent;
      while (bytes_sent - mark < PHASE_BYTES) begin
        draw_buffer(f, n);
        send_buffer(f, n, 1'b0);
      end
    end
    calm = 1'b0;

    settle();
    $display("%0d buffers, %0d bytes sent; %0d verdicts checked, %0d mismatches",
             buffers_sent, bytes_sent, verdicts_seen, mismatches);
    $display("length limits 19, 20, 100, 576, 1500, 65535 and %0d exercised",
             phase_limit[3]);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
